FILE: rtl/slfb_pkg.sv
// Shared constants and types for the seam linear feather blend.
// No dependencies; every other file of the block uses it.
package slfb_pkg;

  localparam int MAX_WIDTH = 4096;

  localparam int COL_W  = 12;
  localparam int PIX_W  = 8;
  localparam int SPAN_W = 13;
  localparam int ACC_W  = 20;
  localparam int IDX_W  = 8;

  localparam logic [SPAN_W-1:0] LW_MAX   = SPAN_W'(MAX_WIDTH);
  localparam logic [SPAN_W-1:0] LW_RESET = SPAN_W'((4096 > MAX_WIDTH) ? MAX_WIDTH : 4096);

  localparam logic [IDX_W-1:0] CFG_SEAM_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_LEFT_WIDTH = IDX_W'(1);

  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_BLEND = 2'd1,
    REG_WARP  = 2'd2
  } region_t;

  // index 0 = red, 1 = green, 2 = blue
  typedef logic [2:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [COL_W-1:0]  seam_start;
    logic [SPAN_W-1:0] left_width;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    pix_t             lft;
    pix_t             wrp;
  } pix_in_t;

  typedef struct packed {
    pix_t    pix;
    region_t region;
  } pix_out_t;

endpackage

FILE: rtl/slfb_in_if.sv
// Input pixel channel: column plus left and warped RGB pixels.
// Uses slfb_pkg for field widths.
interface slfb_in_if;
  logic                       valid;
  logic                       ready;
  logic [slfb_pkg::COL_W-1:0] col;
  logic [slfb_pkg::PIX_W-1:0] left_r;
  logic [slfb_pkg::PIX_W-1:0] left_g;
  logic [slfb_pkg::PIX_W-1:0] left_b;
  logic [slfb_pkg::PIX_W-1:0] warp_r;
  logic [slfb_pkg::PIX_W-1:0] warp_g;
  logic [slfb_pkg::PIX_W-1:0] warp_b;

  modport source (output valid, col, left_r, left_g, left_b, warp_r, warp_g, warp_b,
                  input ready);
  modport sink (input valid, col, left_r, left_g, left_b, warp_r, warp_g, warp_b,
                output ready);
endinterface

FILE: rtl/slfb_out_if.sv
// Result channel: blended RGB pixel and its region code.
// Uses slfb_pkg for field widths and the region type.
interface slfb_out_if;
  logic                       valid;
  logic                       ready;
  logic [slfb_pkg::PIX_W-1:0] out_r;
  logic [slfb_pkg::PIX_W-1:0] out_g;
  logic [slfb_pkg::PIX_W-1:0] out_b;
  logic [1:0]                 region;

  modport source (output valid, out_r, out_g, out_b, region, input ready);
  modport sink (input valid, out_r, out_g, out_b, region, output ready);
endinterface

FILE: rtl/slfb_cfg_if.sv
// Configuration write channel: register index and write data.
// Uses slfb_pkg for widths.
interface slfb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [slfb_pkg::IDX_W-1:0]  index;
  logic [slfb_pkg::SPAN_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/slfb_pipe.sv
// Blend datapath: classify, multiply, add, then eight restoring divide steps.
// Each stage has its own valid bit and stalls only when full and blocked.
// Depends on slfb_pkg.
module slfb_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  slfb_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  slfb_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slfb_pkg::pix_out_t out_data
);

  localparam int NDIV   = slfb_pkg::PIX_W;
  localparam int NST    = NDIV + 3;
  localparam int PIX_W  = slfb_pkg::PIX_W;
  localparam int COL_W  = slfb_pkg::COL_W;
  localparam int SPAN_W = slfb_pkg::SPAN_W;
  localparam int ACC_W  = slfb_pkg::ACC_W;

  typedef struct packed {
    slfb_pkg::region_t region;
    logic              bypass;
    slfb_pkg::pix_t    quo;
    slfb_pkg::pix_t    lft;
    slfb_pkg::pix_t    wrp;
    logic [COL_W-1:0]  k;
    logic [SPAN_W-1:0] wk;
    logic [SPAN_W-1:0] span;
  } cls_t;

  typedef struct packed {
    slfb_pkg::region_t     region;
    logic                  bypass;
    slfb_pkg::pix_t        quo;
    logic [SPAN_W-1:0]     span;
    logic [2:0][ACC_W-1:0] pl;
    logic [2:0][ACC_W-1:0] pw;
  } mul_t;

  typedef struct packed {
    slfb_pkg::region_t     region;
    logic                  bypass;
    slfb_pkg::pix_t        quo;
    logic [SPAN_W-1:0]     span;
    logic [2:0][ACC_W-1:0] rem;
  } div_t;

  logic [NST-1:0] v_r, v_nxt, en, v_in;

  cls_t cls_r, cls_nxt;
  mul_t mul_r, mul_nxt;
  div_t div_r   [NDIV+1];
  div_t div_nxt [NDIV+1];

  // a stage moves when it is empty or the next one moves
  assign en[NST-1] = !v_r[NST-1] || out_ready;
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready = en[0];
  assign v_in     = {v_r[NST-2:0], in_valid};
  assign v_nxt    = (en & v_in) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // classify the column against the seam
  always_comb begin
    logic [SPAN_W-1:0] col_x;
    logic [SPAN_W-1:0] seam_x;
    col_x          = {1'b0, in_data.col};
    seam_x         = {1'b0, cfg.seam_start};
    cls_nxt.lft    = in_data.lft;
    cls_nxt.wrp    = in_data.wrp;
    cls_nxt.k      = in_data.col - cfg.seam_start;
    cls_nxt.span   = cfg.left_width - seam_x;
    cls_nxt.wk     = cfg.left_width - col_x;
    if (col_x >= cfg.left_width) begin
      cls_nxt.region = slfb_pkg::REG_WARP;
      cls_nxt.bypass = 1'b1;
      cls_nxt.quo    = in_data.wrp;
    end else if (in_data.col < cfg.seam_start) begin
      cls_nxt.region = slfb_pkg::REG_LEFT;
      cls_nxt.bypass = 1'b1;
      cls_nxt.quo    = in_data.lft;
    end else begin
      // black warped pixel keeps the left pixel
      cls_nxt.region = slfb_pkg::REG_BLEND;
      cls_nxt.bypass = (in_data.wrp == '0);
      cls_nxt.quo    = in_data.lft;
    end
  end

  // weight products per channel
  always_comb begin
    logic [ACC_W-1:0] lx, wx, wkx, kx;
    mul_nxt.region = cls_r.region;
    mul_nxt.bypass = cls_r.bypass;
    mul_nxt.quo    = cls_r.quo;
    mul_nxt.span   = cls_r.span;
    wkx = {{(ACC_W-SPAN_W){1'b0}}, cls_r.wk};
    kx  = {{(ACC_W-COL_W){1'b0}}, cls_r.k};
    for (int c = 0; c < 3; c++) begin
      lx = {{(ACC_W-PIX_W){1'b0}}, cls_r.lft[c]};
      wx = {{(ACC_W-PIX_W){1'b0}}, cls_r.wrp[c]};
      mul_nxt.pl[c] = lx * wkx;
      mul_nxt.pw[c] = wx * kx;
    end
  end

  // weighted sum; clear the quotient for items that go through the divider
  always_comb begin
    div_nxt[0].region = mul_r.region;
    div_nxt[0].bypass = mul_r.bypass;
    div_nxt[0].quo    = mul_r.bypass ? mul_r.quo : '0;
    div_nxt[0].span   = mul_r.span;
    for (int c = 0; c < 3; c++) begin
      div_nxt[0].rem[c] = mul_r.pl[c] + mul_r.pw[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cls_r <= cls_nxt;
    end
    if (en[1]) begin
      mul_r <= mul_nxt;
    end
    if (en[2]) begin
      div_r[0] <= div_nxt[0];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int B = NDIV - j;

    always_comb begin
      logic [ACC_W:0] sh;
      logic [ACC_W:0] rx;
      div_nxt[j] = div_r[j-1];
      sh = {{(ACC_W+1-SPAN_W){1'b0}}, div_r[j-1].span} << B;
      for (int c = 0; c < 3; c++) begin
        rx = {1'b0, div_r[j-1].rem[c]};
        if (!div_r[j-1].bypass && (rx >= sh)) begin
          div_nxt[j].rem[c]    = div_r[j-1].rem[c] - sh[ACC_W-1:0];
          div_nxt[j].quo[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        div_r[j] <= div_nxt[j];
      end
    end
  end

  assign out_valid       = v_r[NST-1];
  assign out_data.pix    = div_r[NDIV].quo;
  assign out_data.region = div_r[NDIV].region;

`ifndef SYNTHESIS
  // the divider input must give a quotient that fits eight bits
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !div_r[0].bypass |->
      ({div_r[0].rem[0]} < {div_r[0].span, 8'b0}) &&
      ({div_r[0].rem[1]} < {div_r[0].span, 8'b0}) &&
      ({div_r[0].rem[2]} < {div_r[0].span, 8'b0}))
    else $error("blend accumulator out of range");

  // a finished division leaves a remainder below the span
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !div_r[NDIV].bypass |->
      (div_r[NDIV].rem[0] < ACC_W'(div_r[NDIV].span)) &&
      (div_r[NDIV].rem[1] < ACC_W'(div_r[NDIV].span)) &&
      (div_r[NDIV].rem[2] < ACC_W'(div_r[NDIV].span)))
    else $error("divider remainder not below span");

  // refusing input only happens with a full first stage
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0])
    else $error("input refused while first stage empty");

  // only blend items may go through the divider
  a_warp_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && (div_r[NDIV].region != slfb_pkg::REG_BLEND) |-> div_r[NDIV].bypass)
    else $error("non-blend item went through divider");
`endif

endmodule

FILE: rtl/seam_linear_feather_blend.sv
// Seam linear feather blend: one pixel per clock in unless stalled, one result per pixel out.
// Depends on slfb_pkg, the channel interfaces and slfb_pipe.
//
// The block takes one item per clock, while the output is not stalled, through eleven
// register stages: one stage classifies the column, one forms the weight products,
// one adds them, and eight one-bit restoring divide steps produce the quotient by the
// overlap width. Every stage carries its own valid bit, so bubbles close up and input
// keeps flowing while a result waits, until all eleven stages hold items; out_ch.ready
// reaches in_ch.ready through logic only. Configuration writes are always accepted;
// seam_start takes 12 bits and left_width 13 bits, clamped to MAX_WIDTH. Write them
// only while no item is in flight.
module seam_linear_feather_blend (
  input logic        clk,
  input logic        rst_n,
  slfb_in_if.sink    in_ch,
  slfb_out_if.source out_ch,
  slfb_cfg_if.sink   cfg_ch
);

  logic [slfb_pkg::COL_W-1:0]  seam_r, seam_nxt;
  logic [slfb_pkg::SPAN_W-1:0] lw_r, lw_nxt;

  slfb_pkg::cfg_t     cfg;
  slfb_pkg::pix_in_t  in_data;
  slfb_pkg::pix_out_t out_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    seam_nxt = seam_r;
    lw_nxt   = lw_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        slfb_pkg::CFG_SEAM_START: seam_nxt = cfg_ch.data[slfb_pkg::COL_W-1:0];
        slfb_pkg::CFG_LEFT_WIDTH: begin
          lw_nxt = (cfg_ch.data > slfb_pkg::LW_MAX) ? slfb_pkg::LW_MAX : cfg_ch.data;
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seam_r <= '0;
      lw_r   <= slfb_pkg::LW_RESET;
    end else begin
      seam_r <= seam_nxt;
      lw_r   <= lw_nxt;
    end
  end

  assign cfg.seam_start = seam_r;
  assign cfg.left_width = lw_r;

  assign in_data.col    = in_ch.col;
  assign in_data.lft[0] = in_ch.left_r;
  assign in_data.lft[1] = in_ch.left_g;
  assign in_data.lft[2] = in_ch.left_b;
  assign in_data.wrp[0] = in_ch.warp_r;
  assign in_data.wrp[1] = in_ch.warp_g;
  assign in_data.wrp[2] = in_ch.warp_b;

  slfb_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.out_r  = out_data.pix[0];
  assign out_ch.out_g  = out_data.pix[1];
  assign out_ch.out_b  = out_data.pix[2];
  assign out_ch.region = out_data.region;

endmodule

FILE: tb/seam_linear_feather_blend_test.sv
// Self-checking test of seam_linear_feather_blend: feeds pixel items through
// directed and random phases and checks each result against its own blend model.
// Depends on slfb_pkg, the slfb channel interfaces and the block itself.
module seam_linear_feather_blend_test;

  localparam int COL_W       = slfb_pkg::COL_W;
  localparam int PIX_W       = slfb_pkg::PIX_W;
  localparam int SPAN_W      = slfb_pkg::SPAN_W;
  localparam int IDX_W       = slfb_pkg::IDX_W;
  localparam int LATENCY     = 11;
  localparam int SETTLE      = LATENCY + 8;
  localparam int HOLD_CYCLES = 100;
  localparam logic [IDX_W-1:0] CFG_UNUSED_TOP = '1;

  // Predicts one result per accepted pixel and keeps them in arrival order.
  class pixel_ledger;
    logic [COL_W-1:0]   seam_start = '0;
    logic [SPAN_W-1:0]  left_width = slfb_pkg::LW_RESET;
    slfb_pkg::pix_out_t pending_pix[$];
    int                 errors = 0;

    function void write_reg(logic [IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
      if (idx == slfb_pkg::CFG_SEAM_START) begin
        seam_start = data[COL_W-1:0];
      end else if (idx == slfb_pkg::CFG_LEFT_WIDTH) begin
        left_width = (data > slfb_pkg::LW_MAX) ? slfb_pkg::LW_MAX : data;
      end
    endfunction

    function slfb_pkg::pix_out_t predict_blend(slfb_pkg::pix_in_t p);
      slfb_pkg::pix_out_t r;
      int unsigned        span;
      int unsigned        k;
      int unsigned        acc;
      if (p.col >= left_width) begin
        r.pix    = p.wrp;
        r.region = slfb_pkg::REG_WARP;
      end else if (p.col < seam_start) begin
        r.pix    = p.lft;
        r.region = slfb_pkg::REG_LEFT;
      end else begin
        span     = left_width - seam_start;
        k        = p.col - seam_start;
        r.region = slfb_pkg::REG_BLEND;
        // black warped pixel means no warped data here
        if (p.wrp == '0) begin
          r.pix = p.lft;
        end else begin
          for (int c = 0; c < 3; c++) begin
            acc      = int'(p.lft[c]) * (span - k) + int'(p.wrp[c]) * k;
            r.pix[c] = PIX_W'(acc / span);
          end
        end
      end
      return r;
    endfunction

    function void note_pixel(slfb_pkg::pix_in_t p);
      pending_pix = {pending_pix, predict_blend(p)};
    endfunction

    function void check_pixel(slfb_pkg::pix_out_t got);
      slfb_pkg::pix_out_t want;
      if (pending_pix.size() == 0) begin
        $display("%0t: result with nothing pending: r %0d g %0d b %0d region %0d",
                 $time, got.pix[0], got.pix[1], got.pix[2], got.region);
        errors++;
        return;
      end
      want = pending_pix.pop_front();
      if (got.pix[0] !== want.pix[0]) begin
        $display("%0t: out_r mismatch expected %0d actual %0d", $time, want.pix[0], got.pix[0]);
        errors++;
      end
      if (got.pix[1] !== want.pix[1]) begin
        $display("%0t: out_g mismatch expected %0d actual %0d", $time, want.pix[1], got.pix[1]);
        errors++;
      end
      if (got.pix[2] !== want.pix[2]) begin
        $display("%0t: out_b mismatch expected %0d actual %0d", $time, want.pix[2], got.pix[2]);
        errors++;
      end
      if (got.region !== want.region) begin
        $display("%0t: region mismatch expected %0d actual %0d", $time, want.region, got.region);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  slfb_in_if  in_ch();
  slfb_out_if out_ch();
  slfb_cfg_if cfg_ch();

  pixel_ledger ledger = new();

  bit out_stalls;
  bit hold_off_req;

  seam_linear_feather_blend DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch all three channels; note inputs before checking results.
  always @(posedge clk) begin
    slfb_pkg::pix_in_t  seen_in;
    slfb_pkg::pix_out_t seen_out;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        ledger.write_reg(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_in.col = in_ch.col;
        seen_in.lft = {in_ch.left_b, in_ch.left_g, in_ch.left_r};
        seen_in.wrp = {in_ch.warp_b, in_ch.warp_g, in_ch.warp_r};
        ledger.note_pixel(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.pix    = {out_ch.out_b, out_ch.out_g, out_ch.out_r};
        seen_out.region = slfb_pkg::region_t'(out_ch.region);
        ledger.check_pixel(seen_out);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 1;
    end else if (r < 95) begin
      return $urandom_range(2, 4);
    end
    return $urandom_range(10, 30);
  endfunction

  // Receiver pacing: full rate, random stalls, or one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!out_stalls || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  initial begin
    #12000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic slfb_pkg::pix_t rand_pix();
    slfb_pkg::pix_t p;
    for (int c = 0; c < 3; c++) p[c] = rand_chan();
    return p;
  endfunction

  function automatic slfb_pkg::pix_t rgb(int r, int g, int b);
    return {PIX_W'(b), PIX_W'(g), PIX_W'(r)};
  endfunction

  // Bias columns toward the overlap and its edges.
  function automatic logic [COL_W-1:0] pick_col();
    int s;
    int w;
    s = ledger.seam_start;
    w = ledger.left_width;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (w > s) return COL_W'(s + $urandom_range(0, w - s - 1));
        return COL_W'($urandom_range(0, 4095));
      end
      4: begin
        case ($urandom_range(0, 5))
          0:       return COL_W'(s - 1);
          1:       return COL_W'(s);
          2:       return COL_W'(w - 1);
          3:       return COL_W'(w);
          4:       return '0;
          default: return '1;
        endcase
      end
      default: return COL_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_pixel(slfb_pkg::pix_in_t p);
    in_ch.valid  <= 1'b1;
    in_ch.col    <= p.col;
    in_ch.left_r <= p.lft[0];
    in_ch.left_g <= p.lft[1];
    in_ch.left_b <= p.lft[2];
    in_ch.warp_r <= p.wrp[0];
    in_ch.warp_g <= p.wrp[1];
    in_ch.warp_b <= p.wrp[2];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_dir(int col, slfb_pkg::pix_t lft, slfb_pkg::pix_t wrp);
    slfb_pkg::pix_in_t p;
    p.col = COL_W'(col);
    p.lft = lft;
    p.wrp = wrp;
    send_pixel(p);
  endtask

  task automatic idle_input(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold input until every pending result is back and the pipe is empty.
  task automatic drain();
    idle_input(1);
    while (ledger.pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_burst(int n, bit gaps);
    slfb_pkg::pix_in_t p;
    for (int i = 0; i < n; i++) begin
      p.col = pick_col();
      p.lft = rand_pix();
      p.wrp = ($urandom_range(0, 11) == 0) ? slfb_pkg::pix_t'('0) : rand_pix();
      send_pixel(p);
      if (gaps && $urandom_range(0, 9) < 4) idle_input(pick_gap());
    end
    drain();
  endtask

  task automatic set_seam(int seam_data, int lw_data);
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(slfb_pkg::CFG_SEAM_START, SPAN_W'(seam_data));
      cfg_write(slfb_pkg::CFG_LEFT_WIDTH, SPAN_W'(lw_data));
    end else begin
      cfg_write(slfb_pkg::CFG_LEFT_WIDTH, SPAN_W'(lw_data));
      cfg_write(slfb_pkg::CFG_SEAM_START, SPAN_W'(seam_data));
    end
  endtask

  task automatic random_phase(int n);
    int s;
    int w;
    s = $urandom_range(0, 8191);
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom_range(0, 8191);
    end else begin
      w = (s % 4096) + $urandom_range(1, 64);
    end
    set_seam(s, w);
    // writes to unused indexes must leave both registers alone
    cfg_write(IDX_W'($urandom_range(2, 255)), SPAN_W'($urandom_range(0, 8191)));
    out_stalls = $urandom_range(0, 3) != 0;
    run_burst(n, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.col    <= '0;
    in_ch.left_r <= '0;
    in_ch.left_g <= '0;
    in_ch.left_b <= '0;
    in_ch.warp_r <= '0;
    in_ch.warp_g <= '0;
    in_ch.warp_b <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    out_stalls   = 1'b0;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the whole row is one overlap of width 4096.
    send_dir(0, rgb(255, 255, 255), rgb(0, 0, 1));
    send_dir(4095, rgb(0, 0, 0), rgb(255, 255, 255));
    send_dir(4095, rgb(255, 255, 255), rgb(255, 255, 255));
    send_dir(2048, rgb(255, 128, 7), rgb(0, 0, 0));
    send_dir(2048, rgb(170, 170, 170), rgb(85, 85, 85));
    send_dir(1, rgb(0, 255, 0), rgb(255, 0, 255));
    drain();

    // Narrow overlap: both edges, black and partly black warped pixels.
    set_seam(100, 200);
    send_dir(0, rgb(1, 2, 3), rgb(4, 5, 6));
    send_dir(99, rgb(255, 255, 255), rgb(9, 9, 9));
    send_dir(100, rgb(200, 100, 50), rgb(255, 255, 255));
    send_dir(101, rgb(0, 0, 0), rgb(255, 255, 255));
    send_dir(150, rgb(77, 88, 99), rgb(0, 0, 0));
    send_dir(150, rgb(77, 88, 99), rgb(0, 200, 0));
    send_dir(150, rgb(255, 0, 255), rgb(0, 255, 0));
    send_dir(199, rgb(0, 0, 0), rgb(255, 255, 255));
    send_dir(199, rgb(255, 255, 255), rgb(0, 0, 1));
    send_dir(200, rgb(12, 34, 56), rgb(0, 0, 0));
    send_dir(4095, rgb(12, 34, 56), rgb(65, 43, 21));
    drain();
    cfg_write(CFG_UNUSED_TOP, '1);
    send_dir(150, rgb(10, 20, 30), rgb(40, 50, 60));
    drain();

    // Full-width overlap at full rate, then a long output hold-off.
    set_seam(0, 4096);
    out_stalls = 1'b0;
    run_burst(120, 1'b0);
    hold_off_req = 1'b1;
    run_burst(80, 1'b0);

    // One-column overlap at the right edge.
    set_seam(4095, 4096);
    out_stalls = 1'b1;
    run_burst(150, 1'b1);

    // Empty row: everything is warped.
    set_seam(0, 0);
    run_burst(120, 1'b1);

    // Empty overlap with the seam past the left width.
    set_seam(3000, 1000);
    out_stalls = 1'b0;
    run_burst(150, 1'b1);

    // All-ones write data: seam keeps 12 bits, left width clamps.
    set_seam(8191, 8191);
    out_stalls = 1'b1;
    run_burst(120, 1'b1);

    // Seam data with the top bit set, and a one-column overlap mid-row.
    set_seam(13'h1800, 2049);
    run_burst(150, 1'b0);

    set_seam(1000, 3000);
    run_burst(150, 1'b1);

    for (int ph = 0; ph < 7; ph++) random_phase(130);

    while (ledger.pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_pix.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
